// File: hdl/hts_pkg.sv
package hts_pkg;

	localparam int BLINK_PERIOD_DEF  = 80;
	localparam int SETTLE_PASSES_DEF = 50;

	localparam logic [5:0] SET_MIN  = 6'd1;
	localparam logic [5:0] SET_MAX  = 6'd40;
	localparam logic [2:0] BAND_MAX = 3'd5;
	localparam logic [3:0] DIV_MIN  = 4'd1;
	localparam logic [3:0] DIV_MAX  = 4'd10;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_CTRL = 1'b1;

	localparam logic [1:0] KEY_UP   = 2'b01;
	localparam logic [1:0] KEY_DN   = 2'b10;
	localparam logic [1:0] KEY_PAIR = 2'b11;

	// glyph indexes beyond the decimal digits
	localparam logic [3:0] IDX_MARK_A = 4'd10;
	localparam logic [3:0] IDX_MARK_G = 4'd11;
	localparam logic [3:0] IDX_MAX    = 4'd12;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_BAND   = 2'd1,
		MODE_DIV    = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		SAVE_SET  = 2'd0,
		SAVE_BAND = 2'd1,
		SAVE_DIV  = 2'd2
	} save_sel_t;

	// controller state seen by the display side
	typedef struct packed {
		mode_t      mode;
		logic [2:0] band;
		logic [3:0] divider;
		logic [7:0] shown_temp;
		logic       relay;
	} ctrl_view_t;

	function automatic logic [6:0] seg_of(input logic [3:0] idx);
		logic [6:0] seg;
		case (idx)
			4'd0:  seg = 7'h3F;
			4'd1:  seg = 7'h06;
			4'd2:  seg = 7'h5B;
			4'd3:  seg = 7'h4F;
			4'd4:  seg = 7'h66;
			4'd5:  seg = 7'h6D;
			4'd6:  seg = 7'h7D;
			4'd7:  seg = 7'h07;
			4'd8:  seg = 7'h7F;
			4'd9:  seg = 7'h6F;
			4'd10: seg = 7'h01;
			4'd11: seg = 7'h40;
			default: seg = 7'h08;
		endcase
		return seg;
	endfunction

endpackage

// File: hdl/hts_ctrl.sv
module hts_ctrl #(
	parameter int SETTLE_PASSES = hts_pkg::SETTLE_PASSES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   pass,
	input  logic [1:0]             keys,
	input  logic [7:0]             sensor_temp,
	output hts_pkg::ctrl_view_t    view,
	output logic                   relay_nx,
	output logic                   save_valid,
	output logic [1:0]             save_which,
	output logic [5:0]             save_value
);
	import hts_pkg::*;

	localparam int SW = $clog2(SETTLE_PASSES + 1);
	localparam logic [SW-1:0] SETTLE_LOAD = SW'(SETTLE_PASSES);

	mode_t         mode_q, mode_k, mode_n;
	logic [5:0]    set_q, set_k;
	logic [2:0]    band_q, band_k;
	logic [3:0]    div_q, div_k;
	logic          relay_q, relay_c;
	logic [SW-1:0] settle_q, settle_k, settle_n;
	logic [7:0]    shown_q, shown_n;
	logic [6:0]    hi_lim;
	logic [7:0]    lo_lim;
	logic          hi_hit, lo_hit, save_hit;
	save_sel_t     which_c;
	logic [5:0]    value_c;

	// hysteresis compare, lower limit may go negative
	assign hi_lim = {1'b0, set_q} + {4'b0, band_q};
	assign lo_lim = {2'b0, set_q} - {5'b0, band_q};
	assign hi_hit = shown_q >= {1'b0, hi_lim};
	assign lo_hit = !lo_lim[7] && (shown_q <= lo_lim);
	assign relay_c = lo_hit ? 1'b1 : (hi_hit ? 1'b0 : relay_q);

	always_comb begin
		mode_k   = mode_q;
		set_k    = set_q;
		band_k   = band_q;
		div_k    = div_q;
		settle_k = settle_q;
		case (keys)
			KEY_UP, KEY_DN: begin
				settle_k = SETTLE_LOAD;
				if (settle_q != '0) begin
					unique case (mode_q)
						MODE_BAND: begin
							if (keys == KEY_UP) begin
								if (band_q < BAND_MAX) band_k = band_q + 3'd1;
							end else if (band_q != 3'd0) begin
								band_k = band_q - 3'd1;
							end
						end
						MODE_DIV: begin
							if (keys == KEY_UP) begin
								if (div_q < DIV_MAX) div_k = div_q + 4'd1;
							end else if (div_q > DIV_MIN) begin
								div_k = div_q - 4'd1;
							end
						end
						default: begin
							if (keys == KEY_UP) begin
								if (set_q < SET_MAX) set_k = set_q + 6'd1;
							end else if (set_q > SET_MIN) begin
								set_k = set_q - 6'd1;
							end
						end
					endcase
				end
			end
			KEY_PAIR: begin
				settle_k = SETTLE_LOAD;
				unique case (mode_q)
					MODE_BAND: mode_k = MODE_DIV;
					MODE_DIV:  mode_k = MODE_NORMAL;
					default:   mode_k = MODE_BAND;
				endcase
			end
			default: ;
		endcase
	end

	// settle countdown and save
	always_comb begin
		mode_n   = mode_k;
		settle_n = settle_k;
		shown_n  = sensor_temp;
		save_hit = 1'b0;
		if (settle_k != '0) begin
			settle_n = settle_k - 1'b1;
			shown_n  = {2'b0, set_k};
			if (settle_n == '0) begin
				save_hit = 1'b1;
				mode_n   = MODE_NORMAL;
			end
		end
	end

	always_comb begin
		unique case (mode_k)
			MODE_BAND: begin
				which_c = SAVE_BAND;
				value_c = {3'b0, band_k};
			end
			MODE_DIV: begin
				which_c = SAVE_DIV;
				value_c = {2'b0, div_k};
			end
			default: begin
				which_c = SAVE_SET;
				value_c = set_k;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			set_q    <= 6'd20;
			band_q   <= 3'd1;
			div_q    <= 4'd3;
			relay_q  <= 1'b0;
			settle_q <= '0;
			shown_q  <= 8'd20;
		end else if (en && pass) begin
			mode_q   <= mode_n;
			set_q    <= set_k;
			band_q   <= band_k;
			div_q    <= div_k;
			relay_q  <= relay_c;
			settle_q <= settle_n;
			shown_q  <= shown_n;
		end
	end

	assign view.mode       = mode_q;
	assign view.band       = band_q;
	assign view.divider    = div_q;
	assign view.shown_temp = shown_q;
	assign view.relay      = relay_q;

	assign relay_nx   = pass ? relay_c : relay_q;
	assign save_valid = pass && save_hit;
	assign save_which = (pass && save_hit) ? which_c : SAVE_SET;
	assign save_value = (pass && save_hit) ? value_c : 6'd0;

`ifndef ASSERT_OFF
	a_save_returns_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(en && save_valid) |=> (mode_q == MODE_NORMAL && settle_q == '0))
		else $error("save did not return to normal mode");
	a_settings_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(set_q >= SET_MIN && set_q <= SET_MAX && band_q <= BAND_MAX &&
		 div_q >= DIV_MIN && div_q <= DIV_MAX))
		else $error("setting out of range");
`endif
endmodule

// File: hdl/hts_disp.sv
module hts_disp #(
	parameter int BLINK_PERIOD = hts_pkg::BLINK_PERIOD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                tick,
	input  hts_pkg::ctrl_view_t view,
	output logic [7:0]          segments,
	output logic                left_enable,
	output logic                right_enable
);
	import hts_pkg::*;

	localparam int BW = $clog2(BLINK_PERIOD + 1);
	localparam logic [BW-1:0] BLINK_LOAD = BW'(BLINK_PERIOD);
	localparam logic [BW-1:0] BLINK_HALF = BW'(BLINK_PERIOD / 2);

	logic [3:0]    tick_q, tick_inc;
	logic          digit_q;
	logic [BW-1:0] blink_q, blink_n;
	logic [7:0]    latch_q, seg_c;
	logic          hit;
	logic [15:0]   prod;
	logic [4:0]    quo;
	logic [7:0]    rem;
	logic [3:0]    tens, idx;

	assign tick_inc = tick_q + 4'd1;
	assign hit      = tick_inc >= view.divider;

	// divide by ten as multiply by 205 and shift, exact for a byte
	assign prod = {8'b0, view.shown_temp} * 16'd205;
	assign quo  = prod[15:11];
	assign rem  = view.shown_temp - ({quo, 3'b0} + {2'b0, quo, 1'b0});
	assign tens = (quo > 5'd9) ? 4'd9 : quo[3:0];

	always_comb begin
		unique case (view.mode)
			MODE_BAND: idx = digit_q ? IDX_MARK_A : {1'b0, view.band};
			MODE_DIV:  idx = digit_q ? IDX_MARK_G : view.divider;
			default:   idx = digit_q ? tens : rem[3:0];
		endcase
		if (idx > IDX_MAX) idx = IDX_MAX;
	end

	always_comb begin
		seg_c   = {1'b0, seg_of(idx)};
		blink_n = blink_q;
		if (digit_q) begin
			if (blink_q < BLINK_HALF) seg_c[7] = 1'b1;
			blink_n = (blink_q == '0) ? BLINK_LOAD : blink_q - 1'b1;
		end else begin
			seg_c[7] = view.relay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			digit_q <= 1'b0;
			blink_q <= BLINK_LOAD;
			latch_q <= 8'hFF;
		end else if (en && tick) begin
			tick_q <= hit ? 4'd0 : tick_inc;
			if (hit) begin
				latch_q <= seg_c;
				digit_q <= !digit_q;
				blink_q <= blink_n;
			end
		end
	end

	assign segments     = (tick && hit) ? seg_c : latch_q;
	assign left_enable  = tick && hit && digit_q;
	assign right_enable = tick && hit && !digit_q;

`ifndef ASSERT_OFF
	a_digit_alternates: assert property (@(posedge clk) disable iff (!arst_n)
		(en && (left_enable || right_enable)) |=> (digit_q != $past(digit_q)))
		else $error("digit select did not toggle on update");
	a_blink_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		blink_q <= BLINK_LOAD)
		else $error("blink counter beyond period");
`endif
endmodule

// File: hdl/hysteresis_thermostat_with_display_unit.sv
// Thermostat with a two-digit multiplexed display. Each request is either a
// display refresh tick (action 0) or a control pass (action 1) and yields
// exactly one result, which passes from the input register to the result
// register, so a new request is taken every cycle while the consumer takes
// results; the result register holds a finished result while the consumer
// stalls and the input register takes one more. A control pass drives the
// relay with hysteresis, applies the keys to the setting of the current edit
// mode and runs the settle countdown that reports a setting to persist. The
// ticks, divided by the refresh divider, light the left and right digits in turn.
module hysteresis_thermostat_with_display_unit #(
	parameter int BLINK_PERIOD  = hts_pkg::BLINK_PERIOD_DEF,
	parameter int SETTLE_PASSES = hts_pkg::SETTLE_PASSES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic       action,
	input  logic [1:0] keys,
	input  logic [7:0] sensor_temp,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] segments,
	output logic       left_enable,
	output logic       right_enable,
	output logic       relay,
	output logic       save_valid,
	output logic [1:0] save_which,
	output logic [5:0] save_value
);
	import hts_pkg::*;

	logic       valid_s1, action_s1, adv;
	logic [1:0] keys_s1;
	logic [7:0] sensor_temp_s1;

	ctrl_view_t view;
	logic       relay_c, save_valid_c;
	logic [1:0] save_which_c;
	logic [5:0] save_value_c;
	logic [7:0] segments_c;
	logic       left_c, right_c;

	logic       valid_s2, relay_s2, left_s2, right_s2, save_valid_s2;
	logic [7:0] segments_s2;
	logic [1:0] save_which_s2;
	logic [5:0] save_value_s2;

	assign adv        = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			action_s1      <= action;
			keys_s1        <= keys;
			sensor_temp_s1 <= sensor_temp;
		end
	end

	hts_ctrl #(
		.SETTLE_PASSES(SETTLE_PASSES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.pass       (action_s1 == ACT_CTRL),
		.keys       (keys_s1),
		.sensor_temp(sensor_temp_s1),
		.view       (view),
		.relay_nx   (relay_c),
		.save_valid (save_valid_c),
		.save_which (save_which_c),
		.save_value (save_value_c)
	);

	hts_disp #(
		.BLINK_PERIOD(BLINK_PERIOD)
	) u_disp (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.tick        (action_s1 == ACT_TICK),
		.view        (view),
		.segments    (segments_c),
		.left_enable (left_c),
		.right_enable(right_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			segments_s2   <= segments_c;
			left_s2       <= left_c;
			right_s2      <= right_c;
			relay_s2      <= relay_c;
			save_valid_s2 <= save_valid_c;
			save_which_s2 <= save_which_c;
			save_value_s2 <= save_value_c;
		end
	end

	assign result_valid = valid_s2;
	assign segments     = segments_s2;
	assign left_enable  = left_s2;
	assign right_enable = right_s2;
	assign relay        = relay_s2;
	assign save_valid   = save_valid_s2;
	assign save_which   = save_which_s2;
	assign save_value   = save_value_s2;

`ifndef ASSERT_OFF
	a_one_digit_lit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0({left_s2, right_s2}))
		else $error("both digits enabled");
	a_no_save_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !save_valid_s2) |-> (save_which_s2 == SAVE_SET && save_value_s2 == 6'd0))
		else $error("save fields set without save");
`endif
endmodule

// File: tb/tb_hysteresis_thermostat_with_display_unit.sv
`timescale 1ns / 100ps

module tb_hysteresis_thermostat_with_display_unit;
	import hts_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int DIRECTED_MAX  = 25;
	localparam int RANDOM_TARGET = 1550;
	localparam int IDLE_PERCENT  = 18;
	localparam int HOLD_CYCLES   = 60;
	localparam int SETTLE        = SETTLE_PASSES_DEF;
	localparam int BLINK         = BLINK_PERIOD_DEF;

	typedef struct packed {
		logic [7:0] segments;
		logic       left_enable;
		logic       right_enable;
		logic       relay;
		logic       save_valid;
		logic [1:0] save_which;
		logic [5:0] save_value;
	} thermo_result_t;

	// shadow copy of the thermostat and the results it still owes
	class thermostat_tracker;
		mode_t      mode        = MODE_NORMAL;
		logic [5:0] set_point   = 6'd20;
		logic [2:0] band        = 3'd1;
		logic [3:0] divider     = 4'd3;
		logic       heat_on     = 1'b0;
		logic [5:0] settle_left = '0;
		logic [7:0] shown       = 8'd20;
		logic [3:0] tick_phase  = '0;
		logic       left_next   = 1'b0;
		logic [6:0] blink_left  = 7'(BLINK);
		logic [7:0] latch       = 8'hFF;
		logic [6:0] glyph [0:12] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D,
			7'h07, 7'h7F, 7'h6F, 7'h01, 7'h40, 7'h08};
		thermo_result_t pending_results [$];
		int mismatch_count = 0;

		function void take_request(logic act, logic [1:0] k, logic [7:0] s);
			thermo_result_t r;
			int t;
			logic [3:0] idx;
			logic [7:0] seg;
			r = '0;
			if (act == ACT_CTRL) begin
				t = int'(shown);
				if (t >= int'(set_point) + int'(band)) heat_on = 1'b0;
				// on wins, checked last
				if (t <= int'(set_point) - int'(band)) heat_on = 1'b1;
				if (k == KEY_UP || k == KEY_DN) begin
					// a lone key only edits once the countdown is running
					if (settle_left != 0) begin
						case (mode)
							MODE_BAND: begin
								if (k == KEY_UP && band < BAND_MAX) band++;
								else if (k == KEY_DN && band > 0) band--;
							end
							MODE_DIV: begin
								if (k == KEY_UP && divider < DIV_MAX) divider++;
								else if (k == KEY_DN && divider > DIV_MIN) divider--;
							end
							default: begin
								if (k == KEY_UP && set_point < SET_MAX) set_point++;
								else if (k == KEY_DN && set_point > SET_MIN) set_point--;
							end
						endcase
					end
					settle_left = 6'(SETTLE);
				end else if (k == KEY_PAIR) begin
					case (mode)
						MODE_BAND: mode = MODE_DIV;
						MODE_DIV:  mode = MODE_NORMAL;
						default:   mode = MODE_BAND;
					endcase
					settle_left = 6'(SETTLE);
				end
				if (settle_left != 0) begin
					settle_left--;
					if (settle_left == 0) begin
						r.save_valid = 1'b1;
						case (mode)
							MODE_BAND: begin
								r.save_which = SAVE_BAND;
								r.save_value = 6'(band);
							end
							MODE_DIV: begin
								r.save_which = SAVE_DIV;
								r.save_value = 6'(divider);
							end
							default: begin
								r.save_which = SAVE_SET;
								r.save_value = set_point;
							end
						endcase
						mode = MODE_NORMAL;
					end
					shown = 8'(set_point);
				end else begin
					shown = s;
				end
			end else begin
				tick_phase++;
				if (tick_phase >= divider) begin
					tick_phase = '0;
					case (mode)
						MODE_BAND: idx = left_next ? IDX_MARK_A : 4'(band);
						MODE_DIV:  idx = left_next ? IDX_MARK_G : divider;
						default: begin
							if (left_next) idx = (shown / 10 > 9) ? 4'd9 : 4'(shown / 10);
							else idx = 4'(shown % 10);
						end
					endcase
					if (idx > IDX_MAX) idx = IDX_MAX;
					seg = {1'b0, glyph[idx]};
					if (left_next) begin
						if (blink_left < 7'(BLINK / 2)) seg[7] = 1'b1;
						if (blink_left != 0) blink_left--;
						else blink_left = 7'(BLINK);
						r.left_enable = 1'b1;
					end else begin
						seg[7] = heat_on;
						r.right_enable = 1'b1;
					end
					latch = seg;
					left_next = ~left_next;
				end
			end
			r.segments = latch;
			r.relay = heat_on;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string what, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$display("%0t mismatch on %s: expected %0h actual %0h", $time, what, want, got);
				mismatch_count++;
			end
		endfunction

		function void match_result(thermo_result_t got);
			thermo_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: expected none actual %0h", $time, got);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("segments", want.segments, got.segments);
				compare_field("left_enable", 8'(want.left_enable), 8'(got.left_enable));
				compare_field("right_enable", 8'(want.right_enable), 8'(got.right_enable));
				compare_field("relay", 8'(want.relay), 8'(got.relay));
				compare_field("save_valid", 8'(want.save_valid), 8'(got.save_valid));
				compare_field("save_which", 8'(want.save_which), 8'(got.save_which));
				compare_field("save_value", 8'(want.save_value), 8'(got.save_value));
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	logic       action = 1'b0;
	logic [1:0] keys = '0;
	logic [7:0] sensor_temp = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [7:0] segments;
	logic       left_enable;
	logic       right_enable;
	logic       relay;
	logic       save_valid;
	logic [1:0] save_which;
	logic [5:0] save_value;

	thermostat_tracker board = new;
	int  sent_count = 0;
	bit  quiet_stretch = 1'b0;
	bit  hold_off_request = 1'b0;

	hysteresis_thermostat_with_display_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.keys         (keys),
		.sensor_temp  (sensor_temp),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.segments     (segments),
		.left_enable  (left_enable),
		.right_enable (right_enable),
		.relay        (relay),
		.save_valid   (save_valid),
		.save_which   (save_which),
		.save_value   (save_value)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			board.match_result({segments, left_enable, right_enable, relay,
				save_valid, save_which, save_value});
	end

	// consumer side, with random stalls and a long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				result_ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_off_request = 1'b0;
			end else if (quiet_stretch) begin
				result_ready = 1'b1;
			end else begin
				result_ready = ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// call right after a falling edge; returns right after a falling edge
	task automatic offer_request(input logic a, input logic [1:0] k, input logic [7:0] s);
		if (!quiet_stretch) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				item_valid = 1'b0;
				@(negedge clk);
			end
		end
		item_valid = 1'b1;
		action = a;
		keys = k;
		sensor_temp = s;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		board.take_request(a, k, s);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid = 1'b0;
		while (board.pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// random bytes, sensor values near the set point, across the hundreds, and at the rails
	function automatic logic [7:0] pick_sensor();
		int v;
		case ($urandom_range(5))
			0: return 8'($urandom);
			1: return 8'($urandom_range(255, 96));
			2: return $urandom_range(1) ? 8'd0 : 8'd255;
			default: begin
				v = $urandom_range(14);
				v = v + int'(board.set_point) - 7;
				if (v < 0) v = 0;
				return v[7:0];
			end
		endcase
	endfunction

	initial begin
		int kind;
		int len;
		int stage;
		logic [1:0] dir;
		stage = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset display, then relay swings and a saturated tens digit
		repeat (6) offer_request(ACT_TICK, 2'b00, 8'h00);
		offer_request(ACT_CTRL, 2'b00, 8'd0);
		offer_request(ACT_CTRL, 2'b00, 8'd255);
		offer_request(ACT_CTRL, 2'b00, 8'd150);
		repeat (6) offer_request(ACT_TICK, 2'b11, 8'hFF);
		// first lone key only starts the countdown, next ones edit
		offer_request(ACT_CTRL, KEY_UP, 8'd100);
		offer_request(ACT_CTRL, KEY_UP, 8'd99);
		offer_request(ACT_CTRL, KEY_DN, 8'd0);
		offer_request(ACT_CTRL, KEY_PAIR, 8'd7);
		offer_request(ACT_CTRL, KEY_DN, 8'd7);
		offer_request(ACT_CTRL, KEY_PAIR, 8'd7);
		offer_request(ACT_CTRL, KEY_UP, 8'd7);
		offer_request(ACT_CTRL, KEY_PAIR, 8'd7);
		if (sent_count > DIRECTED_MAX) $display("%0t directed part too long", $time);
		wait_drained();

		while (sent_count < RANDOM_TARGET) begin
			kind = $urandom_range(9);
			if (kind < 2) begin
				len = $urandom_range(8, 1);
				repeat (len) offer_request(1'($urandom), 2'($urandom), 8'($urandom));
			end else if (kind < 5) begin
				repeat ($urandom_range(2)) offer_request(ACT_CTRL, KEY_PAIR, pick_sensor());
				dir = $urandom_range(1) ? KEY_UP : KEY_DN;
				len = $urandom_range(42, 1);
				repeat (len) begin
					if ($urandom_range(3) == 0) offer_request(ACT_TICK, 2'($urandom), pick_sensor());
					offer_request(ACT_CTRL, dir, pick_sensor());
				end
			end else begin
				// keys released, in some runs long enough for the countdown to expire
				len = $urandom_range(90, 20);
				repeat (len) begin
					if ($urandom_range(9) < 6) offer_request(ACT_CTRL, 2'b00, pick_sensor());
					else offer_request(ACT_TICK, 2'($urandom), pick_sensor());
				end
			end

			if (stage == 0 && sent_count > 400) begin
				hold_off_request = 1'b1;
				stage = 1;
			end else if (stage == 1 && sent_count > 700) begin
				quiet_stretch = 1'b1;
				stage = 2;
			end else if (stage == 2 && sent_count > 900) begin
				quiet_stretch = 1'b0;
				wait_drained();
				stage = 3;
			end else if (stage == 3 && sent_count > 1200) begin
				hold_off_request = 1'b1;
				stage = 4;
			end
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (board.mismatch_count == 0 && board.pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#(8_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
hdl/hts_pkg.sv
hdl/hts_ctrl.sv
hdl/hts_disp.sv
hdl/hysteresis_thermostat_with_display_unit.sv
tb/tb_hysteresis_thermostat_with_display_unit.sv
